// ===== sv/fqir_pkg.sv =====
`timescale 1ns / 1ps
package fqir_pkg;

  localparam int DataW  = 32;
  localparam int PosW   = 4;
  localparam int CountW = 5;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;

  localparam int DefaultDepth     = 16;
  localparam int DefaultDataWidth = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/fqir_in_if.sv =====
`timescale 1ns / 1ps
interface fqir_in_if;
  import fqir_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [DataW-1:0] item_data;
  logic [PosW-1:0] position;

  modport source (output valid, command, item_data, position, input ready);
  modport sink (input valid, command, item_data, position, output ready);
endinterface

// ===== sv/fqir_out_if.sv =====
`timescale 1ns / 1ps
interface fqir_out_if;
  import fqir_pkg::*;

  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [DataW-1:0]  head_data;
  logic              head_valid;
  logic [CountW-1:0] entry_count;
  logic [DataW-1:0]  removed_data;

  modport source (output valid, status, head_data, head_valid, entry_count, removed_data,
                  input ready);
  modport sink (input valid, status, head_data, head_valid, entry_count, removed_data,
                output ready);
endinterface

// ===== sv/fqir_cell.sv =====
`timescale 1ns / 1ps
module fqir_cell #(
  parameter int W = fqir_pkg::DefaultDataWidth
) (
  input  logic                 clk,
  input  fqir_pkg::cell_ctrl_t ctrl,
  input  logic [W-1:0]         din,
  input  logic [W-1:0]         nbr,
  output logic [W-1:0]         q
);
  import fqir_pkg::*;

  // load writes the tail word, shift takes the word of the next cell
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= din;
    end else if (ctrl.shift) begin
      q <= nbr;
    end
  end

endmodule

// ===== sv/fifo_queue_indexed_remove_unit.sv =====
`timescale 1ns / 1ps
// Bounded FIFO of data words with removal at any position.
// req channel: one item holds a command (push, remove at position, clear,
// query), a data word for push and a position for remove.
// rsp channel: one item per request with status, head word and its valid
// flag, entry count and the word taken out by a successful remove.
// Entries sit in a row of DEPTH cells, head in cell 0. A push loads the
// cell at the count; a remove makes every cell from the position onwards
// take its neighbour's word, all cells in the same cycle.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one item per cycle unless stalled, set by the row's single update.
// The response register is the only buffer: while it holds an item that the
// receiver stalls, req.ready is low and the queue does not change. It is
// freed in the same cycle as it is taken, so back-to-back flow continues.
// Reset: count and the response valid flag clear; cell contents are left
// as they are and are never shown before being written.
module fifo_queue_indexed_remove_unit #(
  parameter int DEPTH      = fqir_pkg::DefaultDepth,
  parameter int DATA_WIDTH = fqir_pkg::DefaultDataWidth
) (
  input logic       clk,
  input logic       rst,
  fqir_in_if.sink   req,
  fqir_out_if.source rsp
);
  import fqir_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > PosW) ? CW : PosW;
  localparam int RD   = (DEPTH < (1 << PosW)) ? DEPTH : (1 << PosW);

  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  cell_ctrl_t            ctrl [DEPTH];
  logic                  out_valid;
  status_t               stat;
  status_t               stat_next;
  logic [DATA_WIDTH-1:0] removed;
  logic [DATA_WIDTH-1:0] removed_next;
  logic [DATA_WIDTH-1:0] word;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic                  acc;
  logic                  push_ok;
  logic                  remove_ok;
  cmd_t                  cmd;

  assign req.ready = !out_valid || rsp.ready;
  assign acc       = req.valid && req.ready;
  assign cmd       = cmd_t'(req.command);
  assign word      = DATA_WIDTH'(req.item_data);
  assign pos_ext   = CMPW'(req.position);
  assign cnt_ext   = CMPW'(cnt);

  always_comb begin
    stat_next    = ST_OK;
    push_ok      = 1'b0;
    remove_ok    = 1'b0;
    cnt_next     = cnt;
    removed_next = '0;
    unique case (cmd)
      CMD_PUSH: begin
        if (cnt == CW'(DEPTH)) begin
          stat_next = ST_FULL;
        end else begin
          push_ok  = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (cnt == '0) begin
          stat_next = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          stat_next = ST_RANGE;
        end else begin
          remove_ok = 1'b1;
          cnt_next  = cnt - CW'(1);
          for (int j = 0; j < RD; j++) begin
            if (req.position == PosW'(j)) begin
              removed_next = cell_q[j];
            end
          end
        end
      end
      CMD_CLEAR: cnt_next = '0;
      CMD_QUERY: ;
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_q[i];
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    assign ctrl[i].load  = acc && push_ok && (cnt == CW'(i));
    assign ctrl[i].shift = acc && remove_ok && (CMPW'(i) >= pos_ext);

    fqir_cell #(.W(DATA_WIDTH)) u_cell (
      .clk  (clk),
      .ctrl (ctrl[i]),
      .din  (word),
      .nbr  (nbr),
      .q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stat    <= stat_next;
      removed <= removed_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = stat;
  assign rsp.head_valid   = (cnt != '0);
  assign rsp.head_data    = (cnt != '0) ? DataW'(cell_q[0]) : '0;
  assign rsp.entry_count  = CountW'(cnt);
  assign rsp.removed_data = DataW'(removed);

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while response stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (cnt == CW'(DEPTH)))
    else $error("full status with spare room");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.removed_data != '0) |-> (rsp.status == ST_OK))
    else $error("removed word with failing status");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !acc) |=> $stable(cnt))
    else $error("count changed without an item");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import fqir_pkg::*;

  localparam int Depth      = DefaultDepth;
  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 11;
  localparam int QuietFrom  = 600;
  localparam int QuietTo    = 1100;
  localparam int RandomItems = 1050;

  typedef struct {
    cmd_t             cmd;
    logic [DataW-1:0] word;
    logic [PosW-1:0]  pos;
    bit               drain;
  } queue_cmd_t;

  typedef struct {
    status_t           status;
    logic [DataW-1:0]  head;
    logic              head_valid;
    logic [CountW-1:0] count;
    logic [DataW-1:0]  removed;
  } queue_rsp_t;

  logic clk = 1'b0;
  logic rst;

  fqir_in_if  req_if ();
  fqir_out_if rsp_if ();

  fifo_queue_indexed_remove_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queue_cmd_t       cmd_backlog[$];
  queue_rsp_t       expected_rsp[$];
  logic [DataW-1:0] shadow_words[Depth];
  int               shadow_count = 0;
  int               gen_count = 0;
  int               failures = 0;
  int               cycle_count = 0;

  function automatic bit idle_now();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) return 1'b0;
    return $urandom_range(0, 99) < IdlePct;
  endfunction

  function automatic queue_rsp_t next_response(cmd_t cmd, logic [DataW-1:0] word,
                                               logic [PosW-1:0] pos);
    queue_rsp_t r;
    int i;
    r.status  = ST_OK;
    r.removed = '0;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = word;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.removed = shadow_words[pos];
          for (i = int'(pos); i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
      end
      CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.head       = (shadow_count > 0) ? shadow_words[0] : '0;
    r.head_valid = (shadow_count > 0);
    r.count      = CountW'(shadow_count);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid     <= 1'b0;
      req_if.command   <= CMD_QUERY;
      req_if.item_data <= '0;
      req_if.position  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp.push_back(next_response(cmd_t'(req_if.command), req_if.item_data,
                                             req_if.position));
      end
      if (!req_if.valid || req_if.ready) begin
        if (cmd_backlog.size() > 0 && !idle_now() &&
            !(cmd_backlog[0].drain && expected_rsp.size() > 0)) begin
          req_if.valid     <= 1'b1;
          req_if.command   <= cmd_backlog[0].cmd;
          req_if.item_data <= cmd_backlog[0].word;
          req_if.position  <= cmd_backlog[0].pos;
          void'(cmd_backlog.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    queue_rsp_t e;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          failures++;
          if (failures <= 10) $display("%0t: response item with none expected", $realtime);
        end else begin
          e = expected_rsp.pop_front();
          if (e.status !== rsp_if.status || e.head !== rsp_if.head_data ||
              e.head_valid !== rsp_if.head_valid || e.count !== rsp_if.entry_count ||
              e.removed !== rsp_if.removed_data) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch exp st=%0d head=%h hv=%b cnt=%0d rem=%h", $realtime,
                       e.status, e.head, e.head_valid, e.count, e.removed);
              $display("%0t:          got st=%0d head=%h hv=%b cnt=%0d rem=%h", $realtime,
                       rsp_if.status, rsp_if.head_data, rsp_if.head_valid,
                       rsp_if.entry_count, rsp_if.removed_data);
            end
          end
        end
      end
      rsp_if.ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("fifo_queue_indexed_remove_unit regression: fail");
      $finish;
    end
  end

  task automatic add_cmd(cmd_t cmd, logic [DataW-1:0] word, logic [PosW-1:0] pos,
                         bit drain = 1'b0);
    queue_cmd_t c;
    c.cmd   = cmd;
    c.word  = word;
    c.pos   = pos;
    c.drain = drain;
    cmd_backlog.push_back(c);
    case (cmd)
      CMD_PUSH:   if (gen_count < Depth) gen_count++;
      CMD_REMOVE: if (gen_count > 0 && int'(pos) < gen_count) gen_count--;
      CMD_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  initial begin
    int i;
    int push_w;
    int roll;
    logic [PosW-1:0] p;
    rst = 1'b1;

    // directed: empty, fill to full, overflow, edge positions, clears
    add_cmd(CMD_QUERY, $urandom, PosW'($urandom));
    add_cmd(CMD_REMOVE, $urandom, 4'd15);
    add_cmd(CMD_PUSH, 32'h0000_0000, 4'd0);
    add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 4'd15);
    for (i = 2; i < Depth; i++) add_cmd(CMD_PUSH, $urandom, PosW'($urandom));
    add_cmd(CMD_PUSH, 32'hDEAD_0001, 4'd0);
    add_cmd(CMD_REMOVE, $urandom, 4'd15);
    add_cmd(CMD_REMOVE, $urandom, 4'd15);
    add_cmd(CMD_REMOVE, $urandom, 4'd0);
    add_cmd(CMD_REMOVE, $urandom, 4'd7);
    add_cmd(CMD_CLEAR, $urandom, PosW'($urandom));
    add_cmd(CMD_CLEAR, $urandom, PosW'($urandom));
    add_cmd(CMD_REMOVE, $urandom, 4'd0);

    // random: phases of varying push bias so the queue sweeps empty to full
    push_w = 45;
    for (i = 0; i < RandomItems; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: push_w = 25;
          1: push_w = 45;
          default: push_w = 70;
        endcase
      end
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0 && gen_count > 0) p = PosW'($urandom_range(0, gen_count - 1));
      else p = PosW'($urandom);
      if (roll < push_w) add_cmd(CMD_PUSH, $urandom, PosW'($urandom), (i % 350) == 0);
      else if (roll < 90) add_cmd(CMD_REMOVE, $urandom, p, (i % 350) == 0);
      else if (roll < 93) add_cmd(CMD_CLEAR, $urandom, PosW'($urandom), (i % 350) == 0);
      else add_cmd(CMD_QUERY, $urandom, PosW'($urandom), (i % 350) == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || req_if.valid || expected_rsp.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (failures == 0) begin
      $display("fifo_queue_indexed_remove_unit regression: pass");
    end else begin
      $display("fifo_queue_indexed_remove_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fqir_pkg.sv
sv/fqir_in_if.sv
sv/fqir_out_if.sv
sv/fqir_cell.sv
sv/fifo_queue_indexed_remove_unit.sv
sim/testbench.sv
